/* hw/rtl/aarm_pkg.sv */
// shared types, constants and arithmetic helpers of the axis-angle rotation matrix block
`timescale 1ns / 1ps
package aarm_pkg;

    localparam int NUM_CELLS = 69;

    localparam logic signed [37:0] PI_Q30      = 38'sd3373259426;
    localparam logic signed [37:0] HALF_PI_Q30 = 38'sd1686629713;
    localparam logic signed [37:0] TWO_PI_Q30  = 38'sd6746518852;
    localparam logic signed [32:0] CORDIC_GAIN = 33'sh026DD3B6A;
    localparam logic signed [33:0] Q30_ONE     = 34'sd1073741824;

    typedef struct packed {
        logic signed [23:0] x;
        logic signed [23:0] y;
        logic signed [23:0] z;
        logic               zero;
        logic [62:0]        n;
        logic [4:0]         s;
        logic [62:0]        root;
        logic [2:0][61:0]   rem;
        logic [2:0][30:0]   q;
        logic signed [37:0] ang;
        logic signed [32:0] cx;
        logic signed [32:0] cy;
        logic               neg;
    } t_item;

    function automatic logic [31:0] atan_lut(input logic [4:0] i);
        logic [31:0] v;
        case (i)
            5'd0:  v = 32'h3243F6A8;
            5'd1:  v = 32'h1DAC6705;
            5'd2:  v = 32'h0FADBAFC;
            5'd3:  v = 32'h07F56EA6;
            5'd4:  v = 32'h03FEAB76;
            5'd5:  v = 32'h01FFD55B;
            5'd6:  v = 32'h00FFFAAA;
            5'd7:  v = 32'h007FFF55;
            5'd8:  v = 32'h003FFFEA;
            5'd9:  v = 32'h001FFFFD;
            5'd10: v = 32'h000FFFFF;
            5'd11: v = 32'h0007FFFF;
            5'd12: v = 32'h0003FFFF;
            5'd13: v = 32'h0001FFFF;
            5'd14: v = 32'h0000FFFF;
            5'd15: v = 32'h00007FFF;
            5'd16: v = 32'h00003FFF;
            5'd17: v = 32'h00001FFF;
            5'd18: v = 32'h00000FFF;
            5'd19: v = 32'h000007FF;
            5'd20: v = 32'h000003FF;
            5'd21: v = 32'h000001FF;
            5'd22: v = 32'h000000FF;
            5'd23: v = 32'h0000007F;
            5'd24: v = 32'h0000003F;
            5'd25: v = 32'h0000001F;
            5'd26: v = 32'h0000000F;
            5'd27: v = 32'h00000007;
            5'd28: v = 32'h00000003;
            5'd29: v = 32'h00000001;
            default: v = 32'h00000000;
        endcase
        return v;
    endfunction

    function automatic logic signed [33:0] mul30(input logic signed [33:0] a,
                                                 input logic signed [33:0] b);
        logic signed [67:0] p;
        p = a * b;
        return p[63:30];
    endfunction

endpackage

/* hw/rtl/aarm_if.sv */
// channel interfaces for axis-angle input and matrix entry output
`timescale 1ns / 1ps
interface aarm_in_if;
    logic               valid;
    logic               ready;
    logic signed [23:0] axis_x;
    logic signed [23:0] axis_y;
    logic signed [23:0] axis_z;
    logic signed [14:0] angle;

    modport source (output valid, axis_x, axis_y, axis_z, angle, input ready);
    modport sink (input valid, axis_x, axis_y, axis_z, angle, output ready);
endinterface

interface aarm_out_if;
    logic               valid;
    logic               ready;
    logic [1:0]         row_index;
    logic [1:0]         column_index;
    logic signed [15:0] entry_value;
    logic               last_entry;
    logic               axis_zero;

    modport source (output valid, row_index, column_index, entry_value, last_entry, axis_zero,
                    input ready);
    modport sink (input valid, row_index, column_index, entry_value, last_entry, axis_zero,
                  output ready);
endinterface

/* hw/rtl/aarm_cell.sv */
// one cell of the chain: a step of squared length, normalize, square root, divide, angle reduction and cordic
`timescale 1ns / 1ps
module aarm_cell #(
    parameter int IDX             = 0,
    parameter int ANGLE_FRAC_BITS = 12
) (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_adv,
    input  logic           i_vld,
    input  aarm_pkg::t_item i_item,
    output logic           o_vld,
    output aarm_pkg::t_item o_item
);
    import aarm_pkg::*;

    localparam int MOD_STEPS = (ANGLE_FRAC_BITS < 12) ? 12 - ANGLE_FRAC_BITS : 0;
    localparam int NK  = (IDX >= 1 && IDX <= 5) ? (16 >> (IDX - 1)) : 1;
    localparam int SJ  = (IDX >= 6 && IDX <= 36) ? IDX - 6 : 0;
    localparam int DB  = (IDX >= 38 && IDX <= 68) ? 30 - (IDX - 38) : 0;
    localparam int MSH = (IDX >= 1 && IDX <= MOD_STEPS) ? MOD_STEPS - IDX : 0;
    localparam int CI  = (IDX >= MOD_STEPS + 2 && IDX <= MOD_STEPS + 31) ?
                         IDX - MOD_STEPS - 2 : 0;

    localparam logic [62:0] NORM_LIM = 63'd1 << (62 - 2 * NK);
    localparam logic [63:0] SQ_BIT = 64'd1 << (2 * (30 - SJ));
    localparam logic signed [37:0] MOD_T = TWO_PI_Q30 <<< MSH;
    localparam logic signed [37:0] ATAN_C = 38'(atan_lut(5'(CI)));

    logic               r_vld;
    t_item              r_item;
    t_item              n_item;
    logic signed [47:0] w_sqx;
    logic signed [47:0] w_sqy;
    logic signed [47:0] w_sqz;
    logic [62:0]        w_l2;

    assign w_sqx = i_item.x * i_item.x;
    assign w_sqy = i_item.y * i_item.y;
    assign w_sqz = i_item.z * i_item.z;
    assign w_l2  = 63'($unsigned(w_sqx)) + 63'($unsigned(w_sqy)) + 63'($unsigned(w_sqz));

    always_comb begin
        logic [63:0]        trial;
        logic [2:0][23:0]   axis;
        logic [23:0]        mag;
        logic [61:0]        dt;
        logic signed [32:0] sx;
        logic signed [32:0] sy;
        n_item = i_item;
        axis = {i_item.z, i_item.y, i_item.x};
        trial = '0;
        mag = '0;
        dt = '0;
        sx = '0;
        sy = '0;
        // axis path
        if (IDX == 0) begin
            n_item.n    = w_l2;
            n_item.zero = (w_l2 == 63'd0);
            n_item.s    = '0;
            n_item.root = '0;
            n_item.ang  = i_item.ang <<< (30 - ANGLE_FRAC_BITS);
        end
        if (IDX >= 1 && IDX <= 5) begin
            if (i_item.n < NORM_LIM) begin
                n_item.n = i_item.n << (2 * NK);
                n_item.s = i_item.s + 5'(NK);
            end
        end
        if (IDX >= 6 && IDX <= 36) begin
            trial = {1'b0, i_item.root} + SQ_BIT;
            if ({1'b0, i_item.n} >= trial) begin
                n_item.n    = 63'({1'b0, i_item.n} - trial);
                n_item.root = 63'((i_item.root >> 1) + SQ_BIT);
            end else begin
                n_item.root = i_item.root >> 1;
            end
        end
        if (IDX == 37) begin
            for (int l = 0; l < 3; l++) begin
                mag = axis[l][23] ? (~axis[l] + 24'd1) : axis[l];
                n_item.rem[l] = 62'(mag) << (6'(i_item.s) + 6'd30);
                n_item.q[l]   = '0;
            end
        end
        if (IDX >= 38 && IDX <= 68) begin
            dt = 62'(i_item.root[30:0]) << DB;
            for (int l = 0; l < 3; l++) begin
                if (i_item.rem[l] >= dt) begin
                    n_item.rem[l]   = i_item.rem[l] - dt;
                    n_item.q[l][DB] = 1'b1;
                end
            end
        end
        // angle path
        if (IDX >= 1 && IDX <= MOD_STEPS) begin
            if (!i_item.ang[37]) begin
                if (i_item.ang >= MOD_T) begin
                    n_item.ang = i_item.ang - MOD_T;
                end
            end else if (-i_item.ang >= MOD_T) begin
                n_item.ang = i_item.ang + MOD_T;
            end
        end
        if (IDX == MOD_STEPS + 1) begin
            n_item.neg = 1'b0;
            if (n_item.ang > PI_Q30) begin
                n_item.ang = n_item.ang - TWO_PI_Q30;
            end
            if (n_item.ang < -PI_Q30) begin
                n_item.ang = n_item.ang + TWO_PI_Q30;
            end
            if (n_item.ang > HALF_PI_Q30) begin
                n_item.ang = n_item.ang - PI_Q30;
                n_item.neg = 1'b1;
            end else if (n_item.ang < -HALF_PI_Q30) begin
                n_item.ang = n_item.ang + PI_Q30;
                n_item.neg = 1'b1;
            end
            n_item.cx = CORDIC_GAIN;
            n_item.cy = '0;
        end
        if (IDX >= MOD_STEPS + 2 && IDX <= MOD_STEPS + 31) begin
            sx = i_item.cx >>> CI;
            sy = i_item.cy >>> CI;
            if (!i_item.ang[37]) begin
                n_item.cx  = i_item.cx - sy;
                n_item.cy  = i_item.cy + sx;
                n_item.ang = i_item.ang - ATAN_C;
            end else begin
                n_item.cx  = i_item.cx + sy;
                n_item.cy  = i_item.cy - sx;
                n_item.ang = i_item.ang + ATAN_C;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (i_adv) begin
            r_vld <= i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_adv) begin
            r_item <= n_item;
        end
    end

    assign o_vld  = r_vld;
    assign o_item = r_item;
endmodule

/* hw/rtl/aarm_matrix.sv */
// matrix products, entry rounding and column-major entry output
`timescale 1ns / 1ps
module aarm_matrix #(
    parameter int ENTRY_FRAC_BITS = 14
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_vld,
    input  aarm_pkg::t_item  i_item,
    output logic             o_adv,
    aarm_out_if.source       o_out
);
    import aarm_pkg::*;

    localparam int SH = 30 - ENTRY_FRAC_BITS;
    localparam logic signed [39:0] HALF = (SH > 0) ? (40'sd1 <<< (SH - 1)) : 40'sd0;
    localparam logic signed [39:0] LIM  = 40'sd1 <<< ENTRY_FRAC_BITS;

    function automatic logic [15:0] to_entry(input logic signed [33:0] q);
        logic signed [39:0] r;
        r = (40'(q) + HALF) >>> SH;
        if (r > LIM) begin
            r = LIM;
        end else if (r < -LIM) begin
            r = -LIM;
        end
        return r[15:0];
    endfunction

    logic               w_adv;
    logic               w_load;
    logic               w_fire;
    logic signed [33:0] w_u;
    logic signed [33:0] w_v;
    logic signed [33:0] w_w;
    logic signed [33:0] w_sn;
    logic signed [33:0] w_cs;
    logic signed [33:0] w_m [16];

    logic               r1_vld;
    logic               r1_zero;
    logic signed [33:0] r1_u2, r1_v2, r1_w2, r1_uv, r1_uw, r1_vw;
    logic signed [33:0] r1_ws, r1_vs, r1_us, r1_cs, r1_oc;

    logic               r2_vld;
    logic               r2_zero;
    logic signed [33:0] r2_u2, r2_v2, r2_w2, r2_ws, r2_vs, r2_us;
    logic signed [33:0] r2_d00, r2_d11, r2_d22, r2_p01, r2_p02, r2_p12;

    logic               r3_vld;
    logic               r3_zero;
    logic [15:0]        r3_ent [16];

    logic               r_bvld;
    logic               r_bzero;
    logic [3:0]         r_cnt;
    logic [15:0]        r_buf [16];

    assign w_u  = i_item.x[23] ? -$signed({3'b000, i_item.q[0]}) : $signed({3'b000, i_item.q[0]});
    assign w_v  = i_item.y[23] ? -$signed({3'b000, i_item.q[1]}) : $signed({3'b000, i_item.q[1]});
    assign w_w  = i_item.z[23] ? -$signed({3'b000, i_item.q[2]}) : $signed({3'b000, i_item.q[2]});
    assign w_sn = i_item.neg ? -34'(i_item.cy) : 34'(i_item.cy);
    assign w_cs = i_item.neg ? -34'(i_item.cx) : 34'(i_item.cx);

    always_comb begin
        for (int k = 0; k < 16; k++) begin
            w_m[k] = ((k >> 2) == (k & 3)) ? Q30_ONE : 34'sd0;
        end
        if (!r2_zero) begin
            w_m[0]  = r2_u2 + r2_d00;
            w_m[1]  = r2_p01 + r2_ws;
            w_m[2]  = r2_p02 - r2_vs;
            w_m[4]  = r2_p01 - r2_ws;
            w_m[5]  = r2_v2 + r2_d11;
            w_m[6]  = r2_p12 + r2_us;
            w_m[8]  = r2_p02 + r2_vs;
            w_m[9]  = r2_p12 - r2_us;
            w_m[10] = r2_w2 + r2_d22;
        end
    end

    assign w_fire = r_bvld && o_out.ready;
    assign w_load = !r_bvld || (w_fire && (r_cnt == 4'd15));
    assign w_adv  = !r3_vld || w_load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_vld <= 1'b0;
            r2_vld <= 1'b0;
            r3_vld <= 1'b0;
        end else if (w_adv) begin
            r1_vld <= i_vld;
            r2_vld <= r1_vld;
            r3_vld <= r2_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r1_zero <= i_item.zero;
            r1_u2   <= mul30(w_u, w_u);
            r1_v2   <= mul30(w_v, w_v);
            r1_w2   <= mul30(w_w, w_w);
            r1_uv   <= mul30(w_u, w_v);
            r1_uw   <= mul30(w_u, w_w);
            r1_vw   <= mul30(w_v, w_w);
            r1_ws   <= mul30(w_w, w_sn);
            r1_vs   <= mul30(w_v, w_sn);
            r1_us   <= mul30(w_u, w_sn);
            r1_cs   <= w_cs;
            r1_oc   <= Q30_ONE - w_cs;

            r2_zero <= r1_zero;
            r2_u2   <= r1_u2;
            r2_v2   <= r1_v2;
            r2_w2   <= r1_w2;
            r2_ws   <= r1_ws;
            r2_vs   <= r1_vs;
            r2_us   <= r1_us;
            r2_d00  <= mul30(r1_v2 + r1_w2, r1_cs);
            r2_d11  <= mul30(r1_u2 + r1_w2, r1_cs);
            r2_d22  <= mul30(r1_u2 + r1_v2, r1_cs);
            r2_p01  <= mul30(r1_uv, r1_oc);
            r2_p02  <= mul30(r1_uw, r1_oc);
            r2_p12  <= mul30(r1_vw, r1_oc);

            r3_zero <= r2_zero;
            for (int k = 0; k < 16; k++) begin
                r3_ent[k] <= to_entry(w_m[k]);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bvld <= 1'b0;
            r_cnt  <= '0;
        end else begin
            if (w_fire) begin
                r_cnt <= r_cnt + 4'd1;
            end
            if (w_load) begin
                r_bvld <= r3_vld;
                r_cnt  <= '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_bzero <= r3_zero;
            r_buf   <= r3_ent;
        end
    end

    assign o_adv              = w_adv;
    assign o_out.valid        = r_bvld;
    assign o_out.row_index    = r_cnt[1:0];
    assign o_out.column_index = r_cnt[3:2];
    assign o_out.entry_value  = r_buf[r_cnt];
    assign o_out.last_entry   = (r_cnt == 4'd15);
    assign o_out.axis_zero    = r_bzero;
endmodule

/* hw/rtl/axis_angle_rotation_matrix.sv */
// axis-angle to 4x4 homogeneous rotation matrix, chain of cells plus matrix stage
//
//   port     dir  transaction  payload
//   i_in     in   one axis     axis_x, axis_y, axis_z (Q7.16), angle
//   o_out    out  one entry    row_index, column_index, entry_value, last_entry, axis_zero
//
// each transaction on i_in yields 16 transactions on o_out, column-major
// the sustained input rate is set by the entry output port; the chain takes new inputs while earlier ones are in flight
// path: 69 cells, then 3 matrix stages, then the entry buffer
// i_rst_n is synchronous and clears all valid flags and the entry counter
// a stall on o_out freezes the whole chain once the entry buffer and last stage are full
`timescale 1ns / 1ps
module axis_angle_rotation_matrix #(
    parameter int ANGLE_FRAC_BITS = 12,
    parameter int ENTRY_FRAC_BITS = 14
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    aarm_in_if.sink   i_in,
    aarm_out_if.source o_out
);
    import aarm_pkg::*;

    logic  w_adv;
    t_item w_in_item;
    logic  w_vld  [NUM_CELLS + 1];
    t_item w_item [NUM_CELLS + 1];

    always_comb begin
        w_in_item      = '0;
        w_in_item.x    = i_in.axis_x;
        w_in_item.y    = i_in.axis_y;
        w_in_item.z    = i_in.axis_z;
        w_in_item.ang  = {{23{i_in.angle[14]}}, i_in.angle};
    end

    assign w_item[0]  = w_in_item;
    assign w_vld[0]   = i_in.valid;
    assign i_in.ready = w_adv;

    for (genvar g = 0; g < NUM_CELLS; g++) begin : g_cell
        aarm_cell #(
            .IDX             (g),
            .ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_adv   (w_adv),
            .i_vld   (w_vld[g]),
            .i_item  (w_item[g]),
            .o_vld   (w_vld[g + 1]),
            .o_item  (w_item[g + 1])
        );
    end

    aarm_matrix #(
        .ENTRY_FRAC_BITS (ENTRY_FRAC_BITS)
    ) u_matrix (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_vld   (w_vld[NUM_CELLS]),
        .i_item  (w_item[NUM_CELLS]),
        .o_adv   (w_adv),
        .o_out   (o_out)
    );
endmodule
